// ===== design/rvexu_pkg.sv =====
// Shared types and constants for the RV32I execute unit.
// Depends on nothing; every design file imports it.
package rvexu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX_W = 5;

  // Major opcodes (instruction bits 6:0).
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;

  // ALU funct3 codes.
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  // Branch funct3 codes.
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  // Load/store funct3 codes.
  localparam logic [2:0] F3_LB  = 3'b000;
  localparam logic [2:0] F3_LH  = 3'b001;
  localparam logic [2:0] F3_LW  = 3'b010;
  localparam logic [2:0] F3_LBU = 3'b100;
  localparam logic [2:0] F3_LHU = 3'b101;
  localparam logic [2:0] F3_JALR = 3'b000;

  // Memory access kinds and sizes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic [XLEN-1:0] instruction;
    logic [XLEN-1:0] inst_pc;
    logic [XLEN-1:0] src1_value;
    logic [XLEN-1:0] src2_value;
  } exu_in_t;

  typedef struct packed {
    logic [XLEN-1:0]   result_value;
    logic              dest_write;
    logic [RIDX_W-1:0] dest_index;
    logic              taken;
    logic [XLEN-1:0]   next_address;
    logic [XLEN-1:0]   store_value;
    logic [1:0]        memory_kind;
    logic [1:0]        access_size;
    logic              load_unsigned;
    logic              illegal;
  } exu_res_t;

endpackage

// ===== design/rv32i_execute_unit.sv =====
// Top level of the RV32I execute unit: input register, execute logic, result register.
// Depends on rvexu_pkg and rvexu_exec.
//
//   channel   handshake               payload
//   input     start, busy             in_instruction, in_inst_pc, in_src1_value, in_src2_value
//   result    out_valid (one cycle)   out_result_value ... out_illegal
//
// An item is taken whenever start is high and busy is low; busy is low except during reset.
// Every item gives one result, held first in the input register and then in the result
// register. A new item can be taken every cycle.
// Reset clears the valid flags only; items in flight are dropped.
// The receiver cannot stall, so nothing ever holds the pipeline.
module rv32i_execute_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rvexu_pkg::XLEN-1:0]   in_instruction,
  input  logic [rvexu_pkg::XLEN-1:0]   in_inst_pc,
  input  logic [rvexu_pkg::XLEN-1:0]   in_src1_value,
  input  logic [rvexu_pkg::XLEN-1:0]   in_src2_value,
  output logic                         out_valid,
  output logic [rvexu_pkg::XLEN-1:0]   out_result_value,
  output logic                         out_dest_write,
  output logic [rvexu_pkg::RIDX_W-1:0] out_dest_index,
  output logic                         out_taken,
  output logic [rvexu_pkg::XLEN-1:0]   out_next_address,
  output logic [rvexu_pkg::XLEN-1:0]   out_store_value,
  output logic [1:0]                   out_memory_kind,
  output logic [1:0]                   out_access_size,
  output logic                         out_load_unsigned,
  output logic                         out_illegal
);
  import rvexu_pkg::*;

  exu_in_t  in_r, in_nxt;
  logic     in_vld_r, in_vld_nxt;
  exu_res_t res_r, res_nxt;
  logic     out_vld_r, out_vld_nxt;

  assign busy = !rst_n;

  assign in_nxt     = '{instruction: in_instruction, inst_pc: in_inst_pc,
                        src1_value: in_src1_value, src2_value: in_src2_value};
  assign in_vld_nxt = start && !busy;
  assign out_vld_nxt = in_vld_r;

  rvexu_exec u_exec (
    .in_item (in_r),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    res_r <= res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_result_value  = res_r.result_value;
  assign out_dest_write    = res_r.dest_write;
  assign out_dest_index    = res_r.dest_index;
  assign out_taken         = res_r.taken;
  assign out_next_address  = res_r.next_address;
  assign out_store_value   = res_r.store_value;
  assign out_memory_kind   = res_r.memory_kind;
  assign out_access_size   = res_r.access_size;
  assign out_load_unsigned = res_r.load_unsigned;
  assign out_illegal       = res_r.illegal;

endmodule

// ===== design/rvexu_exec.sv =====
// Combinational decode, ALU, branch and address logic for one instruction.
// Depends on rvexu_pkg.
module rvexu_exec (
  input  rvexu_pkg::exu_in_t  in_item,
  output rvexu_pkg::exu_res_t res
);
  import rvexu_pkg::*;

  logic [XLEN-1:0]   ir, pc, a, b;
  logic [6:0]        opc;
  logic [2:0]        f3;
  logic [RIDX_W-1:0] rd;
  logic              alt;
  logic [XLEN-1:0]   imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [XLEN-1:0]   seq_pc, alu_b, alu_out;
  logic              reg_form;

  assign ir  = in_item.instruction;
  assign pc  = in_item.inst_pc;
  assign a   = in_item.src1_value;
  assign b   = in_item.src2_value;
  assign opc = ir[6:0];
  assign f3  = ir[14:12];
  assign rd  = ir[11:7];
  assign alt = ir[30];

  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_u = {ir[31:12], 12'b0};
  assign imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};

  assign seq_pc   = pc + 32'd4;
  assign reg_form = (opc == OPC_OP);
  assign alu_b    = reg_form ? b : imm_i;

  // Shared ALU for OP and OP-IMM; only the register form can subtract.
  always_comb begin
    unique case (f3)
      F3_ADD:  alu_out = (reg_form && alt) ? (a - alu_b) : (a + alu_b);
      F3_SLL:  alu_out = a << alu_b[4:0];
      F3_SLT:  alu_out = {31'b0, $signed(a) < $signed(alu_b)};
      F3_SLTU: alu_out = {31'b0, a < alu_b};
      F3_XOR:  alu_out = a ^ alu_b;
      F3_SR:   alu_out = alt ? XLEN'($signed(a) >>> alu_b[4:0]) : (a >> alu_b[4:0]);
      F3_OR:   alu_out = a | alu_b;
      F3_AND:  alu_out = a & alu_b;
      default: alu_out = '0;
    endcase
  end

  always_comb begin
    logic wr;
    logic cond;
    wr   = 1'b0;
    cond = 1'b0;
    res  = '0;
    res.next_address = seq_pc;
    unique case (opc)
      OPC_LOAD: begin
        if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU) begin
          res.result_value  = a + imm_i;
          res.memory_kind   = MEM_LOAD;
          res.access_size   = f3[1:0];
          res.load_unsigned = f3[2];
          wr                = 1'b1;
        end else begin
          res.illegal = 1'b1;
        end
      end
      OPC_STORE: begin
        res.result_value = a + imm_s;
        res.memory_kind  = MEM_STORE;
        res.access_size  = f3[1:0];
        unique case (f3)
          F3_LB:   res.store_value = {24'b0, b[7:0]};
          F3_LH:   res.store_value = {16'b0, b[15:0]};
          F3_LW:   res.store_value = b;
          default: res = '{next_address: seq_pc, illegal: 1'b1, default: '0};
        endcase
      end
      OPC_OPIMM, OPC_OP: begin
        res.result_value = alu_out;
        wr               = 1'b1;
      end
      OPC_LUI: begin
        res.result_value = imm_u;
        wr               = 1'b1;
      end
      OPC_AUIPC: begin
        res.result_value = pc + imm_u;
        wr               = 1'b1;
      end
      OPC_JAL: begin
        res.result_value = seq_pc;
        res.taken        = 1'b1;
        res.next_address = pc + imm_j;
        wr               = 1'b1;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          res.result_value = seq_pc;
          res.taken        = 1'b1;
          res.next_address = (a + imm_i) & ~32'd1;
          wr               = 1'b1;
        end else begin
          res.illegal = 1'b1;
        end
      end
      OPC_BRANCH: begin
        unique case (f3)
          F3_BEQ:  cond = (a == b);
          F3_BNE:  cond = (a != b);
          F3_BLT:  cond = ($signed(a) < $signed(b));
          F3_BGE:  cond = !($signed(a) < $signed(b));
          F3_BLTU: cond = (a < b);
          F3_BGEU: cond = (a >= b);
          default: res.illegal = 1'b1;
        endcase
        if (cond) begin
          res.taken        = 1'b1;
          res.next_address = pc + imm_b;
        end
      end
      default: res.illegal = 1'b1;
    endcase
    res.dest_write = wr && (rd != '0);
    res.dest_index = wr ? rd : '0;
  end

endmodule

// ===== design/rvexu_checker.sv =====
// Port-level checks on the RV32I execute unit, attached by a bind statement.
// Depends on rvexu_pkg and rv32i_execute_unit.
module rvexu_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [rvexu_pkg::XLEN-1:0]   in_inst_pc,
  input logic                         out_valid,
  input logic                         out_dest_write,
  input logic [rvexu_pkg::RIDX_W-1:0] out_dest_index,
  input logic                         out_taken,
  input logic [rvexu_pkg::XLEN-1:0]   out_next_address,
  input logic [1:0]                   out_memory_kind,
  input logic                         out_illegal
);
  import rvexu_pkg::*;

  // Every accepted item comes out as a result.
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted item produced no result");

  // No result appears without an item taken before it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // A result that does not jump continues at its own pc plus four.
  a_seq_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_taken) |-> (out_next_address == $past(in_inst_pc, 2) + 32'd4))
    else $error("sequential next address mismatch");

  // An illegal word has no side effects.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_illegal) |->
      (!out_dest_write && !out_taken && out_memory_kind == MEM_NONE))
    else $error("illegal item has side effects");

  // Register zero is never written.
  a_no_x0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dest_write) |-> (out_dest_index != '0))
    else $error("write enabled for register zero");

endmodule

bind rv32i_execute_unit rvexu_checker u_rvexu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_inst_pc       (in_inst_pc),
  .out_valid        (out_valid),
  .out_dest_write   (out_dest_write),
  .out_dest_index   (out_dest_index),
  .out_taken        (out_taken),
  .out_next_address (out_next_address),
  .out_memory_kind  (out_memory_kind),
  .out_illegal      (out_illegal)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rv32i_execute_unit: a directed table, then random instructions.
// It predicts every result itself and needs only rvexu_pkg and the RTL.
module tb_top;
  import rvexu_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_LIMIT  = 200;
  localparam int unsigned MAX_PRINTED  = 100;

  // Funct3 values that have no meaning for their opcode.
  localparam logic [2:0] F3_BAD_LOAD   = 3'b011;
  localparam logic [2:0] F3_BAD_STORE  = 3'b011;
  localparam logic [2:0] F3_BAD_BRANCH = 3'b010;
  localparam logic [2:0] F3_BAD_JALR   = 3'b001;

  typedef struct packed {
    logic [31:0] ir;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    exu_res_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_instruction;
  logic [31:0] in_inst_pc;
  logic [31:0] in_src1_value;
  logic [31:0] in_src2_value;
  logic        out_valid;
  logic [31:0] out_result_value;
  logic        out_dest_write;
  logic [4:0]  out_dest_index;
  logic        out_taken;
  logic [31:0] out_next_address;
  logic [31:0] out_store_value;
  logic [1:0]  out_memory_kind;
  logic [1:0]  out_access_size;
  logic        out_load_unsigned;
  logic        out_illegal;

  exu_res_t    pending_results[$];
  stim_row_t   stim_table[$];
  exu_res_t    want_res;
  int unsigned err_count   = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_taken     = 0;
  int unsigned n_illegal   = 0;
  int unsigned cycle_count = 0;

  rv32i_execute_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_instruction    (in_instruction),
    .in_inst_pc        (in_inst_pc),
    .in_src1_value     (in_src1_value),
    .in_src2_value     (in_src2_value),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_dest_write    (out_dest_write),
    .out_dest_index    (out_dest_index),
    .out_taken         (out_taken),
    .out_next_address  (out_next_address),
    .out_store_value   (out_store_value),
    .out_memory_kind   (out_memory_kind),
    .out_access_size   (out_access_size),
    .out_load_unsigned (out_load_unsigned),
    .out_illegal       (out_illegal)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] exec_alu(input logic [2:0] f3, input logic alt,
                                           input logic [31:0] a, input logic [31:0] b,
                                           input logic reg_form);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = b[4:0];
    case (f3)
      F3_ADD:  r = (reg_form && alt) ? a - b : a + b;
      F3_SLL:  r = a << sh;
      F3_SLT:  r = {31'b0, $signed(a) < $signed(b)};
      F3_SLTU: r = {31'b0, a < b};
      F3_XOR:  r = a ^ b;
      F3_SR: begin
        if (alt) r = $signed(a) >>> sh;
        else r = a >> sh;
      end
      F3_OR:   r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

  function automatic exu_res_t predict_exec(input logic [31:0] ir, input logic [31:0] pc,
                                            input logic [31:0] a, input logic [31:0] b);
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        alt;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] seq;
    logic        wr;
    logic        cond;
    exu_res_t    r;
    opc   = ir[6:0];
    f3    = ir[14:12];
    rd    = ir[11:7];
    alt   = ir[30];
    imm_i = {{20{ir[31]}}, ir[31:20]};
    imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
    imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
    imm_u = {ir[31:12], 12'b0};
    imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
    seq   = pc + 32'd4;
    r     = '0;
    r.next_address = seq;
    wr    = 1'b0;
    cond  = 1'b0;
    case (opc)
      OPC_LOAD: begin
        if (f3 == F3_BAD_LOAD || f3 > F3_LHU) begin
          r.illegal = 1'b1;
        end else begin
          r.result_value  = a + imm_i;
          r.memory_kind   = MEM_LOAD;
          r.access_size   = f3[1:0];
          r.load_unsigned = f3[2];
          wr = 1'b1;
        end
      end
      OPC_STORE: begin
        if (f3 > F3_LW) begin
          r.illegal = 1'b1;
        end else begin
          r.result_value = a + imm_s;
          r.memory_kind  = MEM_STORE;
          r.access_size  = f3[1:0];
          case (f3)
            F3_LB:   r.store_value = {24'b0, b[7:0]};
            F3_LH:   r.store_value = {16'b0, b[15:0]};
            default: r.store_value = b;
          endcase
        end
      end
      OPC_OPIMM: begin
        r.result_value = exec_alu(f3, alt, a, imm_i, 1'b0);
        wr = 1'b1;
      end
      OPC_OP: begin
        r.result_value = exec_alu(f3, alt, a, b, 1'b1);
        wr = 1'b1;
      end
      OPC_LUI: begin
        r.result_value = imm_u;
        wr = 1'b1;
      end
      OPC_AUIPC: begin
        r.result_value = pc + imm_u;
        wr = 1'b1;
      end
      OPC_JAL: begin
        r.result_value = seq;
        r.taken        = 1'b1;
        r.next_address = pc + imm_j;
        wr = 1'b1;
      end
      OPC_JALR: begin
        if (f3 != F3_JALR) begin
          r.illegal = 1'b1;
        end else begin
          r.result_value = seq;
          r.taken        = 1'b1;
          r.next_address = (a + imm_i) & ~32'd1;
          wr = 1'b1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  cond = (a == b);
          F3_BNE:  cond = (a != b);
          F3_BLT:  cond = $signed(a) < $signed(b);
          F3_BGE:  cond = !($signed(a) < $signed(b));
          F3_BLTU: cond = (a < b);
          F3_BGEU: cond = (a >= b);
          default: r.illegal = 1'b1;
        endcase
        if (cond) begin
          r.taken        = 1'b1;
          r.next_address = pc + imm_b;
        end
      end
      default: r.illegal = 1'b1;
    endcase
    r.dest_write = wr && (rd != 5'd0);
    r.dest_index = wr ? rd : 5'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Encoding helpers for the directed table
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, 5'd2, 5'd1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {imm, 5'd1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [2:0] f3);
    return {imm[11:5], 5'd2, 5'd1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [2:0] f3);
    return {imm[12], imm[10:5], 5'd2, 5'd1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic exu_res_t mk_res(input logic [31:0] res, input logic dw,
                                      input logic [4:0] idx, input logic [31:0] nxt,
                                      input logic ill);
    exu_res_t r;
    r              = '0;
    r.result_value = res;
    r.dest_write   = dw;
    r.dest_index   = idx;
    r.next_address = nxt;
    r.illegal      = ill;
    return r;
  endfunction

  task automatic add_row(input logic [31:0] ir, input logic [31:0] pc, input logic [31:0] a,
                         input logic [31:0] b, input logic typed, input exu_res_t want);
    stim_row_t row;
    row.ir    = ir;
    row.pc    = pc;
    row.a     = a;
    row.b     = b;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h0000_0000;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h8000_0000;
      3:       v = 32'h7FFF_FFFF;
      4:       v = $urandom_range(0, 63);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly well-formed words with random content; the rest is noise.
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 19))
      0: ;
      1: w[1:0] = 2'b11;
      default: begin
        case ($urandom_range(0, 8))
          0:       w[6:0] = OPC_OP;
          1:       w[6:0] = OPC_OPIMM;
          2:       w[6:0] = OPC_LOAD;
          3:       w[6:0] = OPC_STORE;
          4:       w[6:0] = OPC_BRANCH;
          5:       w[6:0] = OPC_JAL;
          6:       w[6:0] = OPC_JALR;
          7:       w[6:0] = OPC_LUI;
          default: w[6:0] = OPC_AUIPC;
        endcase
      end
    endcase
    // Keep most funct3 fields legal so the decoded paths get most of the traffic.
    if ($urandom_range(0, 3) != 0) begin
      case (w[6:0])
        OPC_LOAD: begin
          case ($urandom_range(0, 4))
            0:       w[14:12] = F3_LB;
            1:       w[14:12] = F3_LH;
            2:       w[14:12] = F3_LW;
            3:       w[14:12] = F3_LBU;
            default: w[14:12] = F3_LHU;
          endcase
        end
        OPC_STORE: begin
          case ($urandom_range(0, 2))
            0:       w[14:12] = F3_LB;
            1:       w[14:12] = F3_LH;
            default: w[14:12] = F3_LW;
          endcase
        end
        OPC_JALR: w[14:12] = F3_JALR;
        OPC_BRANCH: begin
          case ($urandom_range(0, 5))
            0:       w[14:12] = F3_BEQ;
            1:       w[14:12] = F3_BNE;
            2:       w[14:12] = F3_BLT;
            3:       w[14:12] = F3_BGE;
            4:       w[14:12] = F3_BLTU;
            default: w[14:12] = F3_BGEU;
          endcase
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [31:0] ir, input logic [31:0] pc, input logic [31:0] a,
                           input logic [31:0] b, input int unsigned gap, input logic typed,
                           input exu_res_t want);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_instruction <= ir;
    in_inst_pc     <= pc;
    in_src1_value  <= a;
    in_src2_value  <= b;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(predict_exec(ir, pc, a, b));
    n_sent++;
  endtask

  task automatic wait_all_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("ERROR at result %0d: %s", n_checked, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want_res = pending_results.pop_front();
        check_field("result_value", out_result_value, want_res.result_value);
        check_field("dest_write", 32'(out_dest_write), 32'(want_res.dest_write));
        check_field("dest_index", 32'(out_dest_index), 32'(want_res.dest_index));
        check_field("taken", 32'(out_taken), 32'(want_res.taken));
        check_field("next_address", out_next_address, want_res.next_address);
        check_field("store_value", out_store_value, want_res.store_value);
        check_field("memory_kind", 32'(out_memory_kind), 32'(want_res.memory_kind));
        check_field("access_size", 32'(out_access_size), 32'(want_res.access_size));
        check_field("load_unsigned", 32'(out_load_unsigned), 32'(want_res.load_unsigned));
        check_field("illegal", 32'(out_illegal), 32'(want_res.illegal));
        if (want_res.taken) n_taken++;
        if (want_res.illegal) n_illegal++;
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned i;
    int unsigned gap;
    int unsigned n_directed;
    logic        burst;
    logic [31:0] ir;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
    exu_res_t    blank;

    blank          = '0;
    burst          = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_instruction = '0;
    in_inst_pc     = '0;
    in_src1_value  = '0;
    in_src2_value  = '0;

    // Rows with a typed result are the ones whose outcome is plain from the encoding.
    add_row(enc_i(12'h000, F3_ADD, 5'd0, OPC_OPIMM), 32'h0, 32'h0, 32'h0, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h4, 1'b0));
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h0, 1'b1));
    add_row(32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h1004, 1'b1));
    add_row(enc_u(20'hFFFFF, 5'd31, OPC_LUI), 32'h10, 32'h0, 32'h0, 1'b1,
            mk_res(32'hFFFF_F000, 1'b1, 5'd31, 32'h14, 1'b0));
    add_row(enc_u(20'h80000, 5'd1, OPC_AUIPC), 32'h8000_0000, 32'h0, 32'h0, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_ADD, 5'd2), 32'h20, 32'hFFFF_FFFF, 32'h1, 1'b0, blank);
    add_row(enc_r(7'b0100000, F3_ADD, 5'd3), 32'h24, 32'h0, 32'h1, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_SLL, 5'd4), 32'h28, 32'h1, 32'hFFFF_FFFF, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_SLT, 5'd5), 32'h2C, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_SLTU, 5'd6), 32'h30, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, blank);
    // Funct7 bits other than bit 30 must be ignored.
    add_row(enc_r(7'b1011111, F3_XOR, 5'd7), 32'h34, 32'hA5A5_A5A5, 32'hFFFF_0000, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_SR, 5'd8), 32'h38, 32'h8000_0000, 32'hFFFF_FFE0, 1'b0, blank);
    add_row(enc_r(7'b0100000, F3_SR, 5'd9), 32'h3C, 32'h8000_0000, 32'h0000_001F, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_OR, 5'd10), 32'h40, 32'h0F0F_0F0F, 32'hF000_0001, 1'b0, blank);
    add_row(enc_r(7'b0000000, F3_AND, 5'd11), 32'h44, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, blank);
    add_row(enc_i(12'h800, F3_ADD, 5'd12, OPC_OPIMM), 32'h48, 32'h0, 32'h0, 1'b0, blank);
    add_row(enc_i(12'hFFF, F3_SLTU, 5'd13, OPC_OPIMM), 32'h4C, 32'hFFFF_FFFE, 32'h0, 1'b0, blank);
    add_row(enc_i(12'hFFF, F3_SR, 5'd14, OPC_OPIMM), 32'h50, 32'h8000_0001, 32'h0, 1'b0, blank);
    add_row(enc_i(12'h7FF, F3_LB, 5'd15, OPC_LOAD), 32'h54, 32'hFFFF_FFFF, 32'h0, 1'b0, blank);
    add_row(enc_i(12'hFFF, F3_LHU, 5'd16, OPC_LOAD), 32'h58, 32'h0, 32'h0, 1'b0, blank);
    add_row(enc_i(12'hFFF, F3_BAD_LOAD, 5'd5, OPC_LOAD), 32'h200, 32'h1, 32'h1, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h204, 1'b1));
    add_row(enc_s(12'h800, F3_LB), 32'h5C, 32'h0, 32'hFFFF_FFFF, 1'b0, blank);
    add_row(enc_s(12'h7FF, F3_LH), 32'h60, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, blank);
    add_row(enc_s(12'h004, F3_LW), 32'h64, 32'h1000, 32'hDEAD_BEEF, 1'b0, blank);
    add_row(enc_s(12'h7FF, F3_BAD_STORE), 32'h300, 32'h1, 32'h1, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h304, 1'b1));
    add_row(enc_b(13'h1000, F3_BEQ), 32'h0, 32'h7, 32'h7, 1'b0, blank);
    add_row(enc_b(13'h0FFE, F3_BLT), 32'hFFFF_F800, 32'h8000_0000, 32'h0, 1'b0, blank);
    add_row(enc_b(13'h0010, F3_BGEU), 32'h68, 32'h0, 32'h1, 1'b0, blank);
    add_row(enc_b(13'h0000, F3_BAD_BRANCH), 32'h400, 32'h5, 32'h5, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h404, 1'b1));
    add_row({1'b1, 19'b0, 5'd1, OPC_JAL}, 32'h0, 32'h0, 32'h0, 1'b0, blank);
    add_row(enc_i(12'hFFF, F3_JALR, 5'd1, OPC_JALR), 32'hFFFF_FFFC, 32'h0, 32'h0, 1'b0, blank);
    add_row(enc_i(12'h010, F3_BAD_JALR, 5'd1, OPC_JALR), 32'h500, 32'h1, 32'h1, 1'b1,
            mk_res(32'h0, 1'b0, 5'd0, 32'h504, 1'b1));
    n_directed = stim_table.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < n_directed; i++) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
      send_item(stim_table[i].ir, stim_table[i].pc, stim_table[i].a, stim_table[i].b, gap,
                stim_table[i].typed, stim_table[i].want);
    end
    wait_all_results();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // Mix stretches of back-to-back items with stretches of random gaps, chosen at random.
      if (i % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) wait_all_results();
      ir  = pick_word();
      pc  = pick_operand();
      a   = pick_operand();
      b   = ($urandom_range(0, 3) == 0) ? a : pick_operand();
      gap = burst ? 0 : $urandom_range(0, 16);
      send_item(ir, pc, a, b, gap, 1'b0, blank);
    end

    wait_all_results();
    // Keep clocking after the drain to catch any result that has no item behind it.
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("Sent %0d directed and %0d random instructions; %0d results checked.",
             n_directed, n_sent - n_directed, n_checked);
    $display("Of those, %0d changed control flow and %0d were flagged illegal; %0d errors.",
             n_taken, n_illegal, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
